### rtl/fcr_pkg.sv
// Types, constants and name-compare helpers for the FAT12 file chain reader.
`timescale 1ns / 1ps
package fcr_pkg;

    localparam int TABLE_BYTES_DEF  = 8192;
    localparam int ROOT_ENTRIES_DEF = 256;
    localparam int MAX_CHAIN_DEF    = 64;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int SCAN_W    = 13;
    localparam int LAY_NUM_W = 15;
    localparam int BPS_W     = 13;

    localparam logic [1:0] KIND_TABLE = 2'd0;
    localparam logic [1:0] KIND_DIR   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] ST_MORE      = 2'd0;
    localparam logic [1:0] ST_DONE      = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BPS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FATS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REC  = 3'd5;

    localparam logic [7:0]  MARK_DELETED = 8'hE5;
    localparam logic [7:0]  MARK_END     = 8'h00;
    localparam logic [7:0]  ATTR_LABEL   = 8'h08;
    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [15:0] CHAIN_END    = 16'h0FF8;
    localparam logic [11:0] CLUSTER_MASK = 12'hFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] entry_index;
        logic [7:0]  byte_value;
        logic [63:0] base_name;
        logic [23:0] extension;
        logic [7:0]  attributes;
        logic [15:0] first_cluster;
        logic [31:0] buffer_size;
    } fcr_in_t;

    typedef struct packed {
        logic [31:0] source_offset;
        logic [19:0] copy_length;
        logic [1:0]  status;
        logic [31:0] total_written;
        logic        last_item;
    } fcr_out_t;

    typedef struct packed {
        logic [3:0]  len;
        logic [63:0] kept;
    } fcr_cut_t;

    function automatic fcr_cut_t cut_base(input logic [63:0] v);
        fcr_cut_t r;
        logic     stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[63-8*i -: 8] == CHAR_SPACE)
                stop = 1'b1;
            if (!stop)
            begin
                r.kept[63-8*i -: 8] = v[63-8*i -: 8];
                r.len = r.len + 4'd1;
            end
        end
        return r;
    endfunction

    function automatic fcr_cut_t cut_ext(input logic [23:0] v);
        fcr_cut_t r;
        logic     stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (v[23-8*i -: 8] == CHAR_SPACE)
                stop = 1'b1;
            if (!stop)
            begin
                r.kept[23-8*i -: 8] = v[23-8*i -: 8];
                r.len = r.len + 4'd1;
            end
        end
        return r;
    endfunction

    function automatic logic names_match(input logic [63:0] a_name, input logic [23:0] a_ext,
                                         input logic [63:0] b_name, input logic [23:0] b_ext);
        fcr_cut_t an, bn, ae, be;
        an = cut_base(a_name);
        bn = cut_base(b_name);
        ae = cut_ext(a_ext);
        be = cut_ext(b_ext);
        return (an == bn) && (ae == be);
    endfunction

endpackage

### rtl/fcr_div.sv
// Restoring divider, one quotient bit per cycle, for the root directory sector count.
`timescale 1ns / 1ps
module fcr_div #(
    parameter int NW = 15,
    parameter int DW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] quot_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            num_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? (trial - {1'b0, den_reg}) : trial;
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            quot_reg <= {quot_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

### rtl/fat12_file_chain_reader.sv
// Top level of the FAT12 file chain reader: table and directory memories and the read sequencer.
`timescale 1ns / 1ps
// Table-byte and directory-entry writes go straight into the memories. A read first works
// out the image layout (the serial divider for the root directory size and two multiply
// steps), then scans the directory, one read of the directory memory per entry, then walks
// the chain with two single-port reads of the allocation table memory per cluster, and it
// waits in its check and not-found states while the output side stalls. The input is ready
// only between reads. TABLE_BYTES must be a power of two.
module fat12_file_chain_reader
    import fcr_pkg::*;
#(
    parameter int TABLE_BYTES  = TABLE_BYTES_DEF,
    parameter int ROOT_ENTRIES = ROOT_ENTRIES_DEF,
    parameter int MAX_CHAIN    = MAX_CHAIN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  fcr_pkg::fcr_in_t          in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output fcr_pkg::fcr_out_t         out_item,
    input  logic                      cfg_we,
    input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcr_pkg::CFG_W-1:0] cfg_data
);
    import fcr_pkg::*;

    localparam int TBL_AW = $clog2(TABLE_BYTES);
    localparam int DIR_AW = $clog2(ROOT_ENTRIES);
    localparam int N_W    = $clog2(MAX_CHAIN + 1);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DIV      = 11'b00000000010,
        S_LAY1     = 11'b00000000100,
        S_LAY2     = 11'b00000001000,
        S_SCAN_RD  = 11'b00000010000,
        S_SCAN_CHK = 11'b00000100000,
        S_CHECK    = 11'b00001000000,
        S_MUL      = 11'b00010000000,
        S_RDHI     = 11'b00100000000,
        S_NEXT     = 11'b01000000000,
        S_NF       = 11'b10000000000
    } fcr_state_t;

    typedef struct packed {
        logic [63:0] name;
        logic [23:0] ext;
        logic [7:0]  attr;
        logic [15:0] cluster;
    } fcr_dir_t;

    fcr_state_t state_reg, state_next;

    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] rsv_reg;
    logic [2:0]  fats_reg;
    logic [15:0] spf_reg;
    logic [8:0]  rec_reg;

    logic [7:0]  tbl_mem [TABLE_BYTES];
    fcr_dir_t    dir_mem [ROOT_ENTRIES];
    logic [7:0]  tbl_rdata_reg;
    fcr_dir_t    dir_rdata_reg;
    logic [TBL_AW-1:0] tbl_raddr;

    logic [63:0] want_name_reg;
    logic [23:0] want_ext_reg;
    logic [31:0] buf_reg;
    logic [SCAN_W-1:0] scan_idx_reg;
    logic [SCAN_W-1:0] scan_lim;

    logic [19:0] start_reg;
    logic [31:0] doff_reg;
    logic [20:0] csize_reg;
    logic [15:0] c_reg;
    logic [31:0] written_reg;
    logic [N_W-1:0] n_reg;
    logic [31:0] prod_reg;
    logic [20:0] copy_reg;
    logic [7:0]  lo_reg;
    fcr_out_t    pend_reg;
    logic        pend_valid_reg;
    logic        out_valid_reg;
    fcr_out_t    out_reg;

    logic        div_start, div_done;
    logic [LAY_NUM_W-1:0] div_num, div_quot;
    logic [LAY_NUM_W-1:0] root_secs;

    logic        in_xfer;
    logic        out_free;
    logic        c_ok, more, go_on;
    logic        emit;
    fcr_out_t    emit_data;
    logic [16:0] caddr, caddr_hi;
    logic [16:0] widx;
    logic [31:0] remain;
    logic [20:0] copy_next;
    logic [15:0] c_word;
    logic [15:0] c_new;
    logic        entry_end, entry_skip, entry_hit;

    assign in_xfer  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg  <= 13'd512;
            spc_reg  <= 8'd1;
            rsv_reg  <= 16'd1;
            fats_reg <= 3'd2;
            spf_reg  <= 16'd9;
            rec_reg  <= 9'd224;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BPS:  bps_reg  <= cfg_data[12:0];
                CFG_SPC:  spc_reg  <= cfg_data[7:0];
                CFG_RSV:  rsv_reg  <= cfg_data;
                CFG_FATS: fats_reg <= cfg_data[2:0];
                CFG_SPF:  spf_reg  <= cfg_data;
                CFG_REC:  rec_reg  <= cfg_data[8:0];
                default:  ;
            endcase
        end
    end

    assign widx     = 17'(in_item.entry_index);
    assign caddr    = 17'(c_reg) + 17'(c_reg >> 1);
    assign caddr_hi = caddr + 17'd1;
    assign tbl_raddr = (state_reg == S_RDHI) ? caddr_hi[TBL_AW-1:0] : caddr[TBL_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_item.kind == KIND_TABLE)
            tbl_mem[widx[TBL_AW-1:0]] <= in_item.byte_value;
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_item.kind == KIND_DIR && 14'(in_item.entry_index) < 14'(ROOT_ENTRIES))
            dir_mem[in_item.entry_index[DIR_AW-1:0]] <= '{in_item.base_name, in_item.extension,
                                                          in_item.attributes,
                                                          in_item.first_cluster};
        dir_rdata_reg <= dir_mem[scan_idx_reg[DIR_AW-1:0]];
    end

    assign div_start = in_xfer && in_item.kind == KIND_READ;
    assign div_num   = LAY_NUM_W'({rec_reg, 5'b0}) + LAY_NUM_W'(bps_reg) - LAY_NUM_W'(1);

    fcr_div #(
        .NW(LAY_NUM_W),
        .DW(BPS_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (bps_reg),
        .done (div_done),
        .quot (div_quot)
    );

    assign root_secs = (bps_reg == '0) ? '0 : div_quot;
    assign scan_lim  = (13'(rec_reg) < 13'(ROOT_ENTRIES)) ? 13'(rec_reg) : 13'(ROOT_ENTRIES);

    assign entry_end  = dir_rdata_reg.name[63:56] == MARK_END;
    assign entry_skip = dir_rdata_reg.name[63:56] == MARK_DELETED
                        || (dir_rdata_reg.attr & ATTR_LABEL) != 8'd0;
    assign entry_hit  = names_match(dir_rdata_reg.name, dir_rdata_reg.ext,
                                    want_name_reg, want_ext_reg);

    assign c_ok  = c_reg >= 16'd2 && c_reg < CHAIN_END;
    assign more  = c_ok && written_reg < buf_reg;
    assign go_on = more && n_reg < N_W'(MAX_CHAIN);

    assign remain    = buf_reg - written_reg;
    assign copy_next = (32'(csize_reg) > remain) ? remain[20:0] : csize_reg;

    assign c_word = {tbl_rdata_reg, lo_reg};
    assign c_new  = c_reg[0] ? (c_word >> 4) : (c_word & 16'(CLUSTER_MASK));

    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b0;
        emit_data  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (div_start)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_LAY1;
            end
            S_LAY1:    state_next = S_LAY2;
            S_LAY2:    state_next = S_SCAN_RD;
            S_SCAN_RD:
            begin
                if (scan_idx_reg >= scan_lim)
                    state_next = S_NF;
                else
                    state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (entry_end)
                    state_next = S_NF;
                else if (!entry_skip && entry_hit)
                    state_next = S_CHECK;
                else
                    state_next = S_SCAN_RD;
            end
            S_CHECK:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        emit      = 1'b1;
                        emit_data = pend_reg;
                        emit_data.status    = go_on ? ST_MORE : (more ? ST_LIMIT : ST_DONE);
                        emit_data.last_item = !go_on;
                    end
                    else if (!go_on)
                    begin
                        emit      = 1'b1;
                        emit_data.status    = ST_DONE;
                        emit_data.last_item = 1'b1;
                    end
                    state_next = go_on ? S_MUL : S_IDLE;
                end
            end
            S_MUL:     state_next = S_RDHI;
            S_RDHI:    state_next = S_NEXT;
            S_NEXT:    state_next = S_CHECK;
            S_NF:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_data.status    = ST_NOT_FOUND;
                    emit_data.last_item = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_SCAN_CHK || emit)
                pend_valid_reg <= 1'b0;
            else if (state_reg == S_NEXT)
                pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= emit_data;
        if (div_start)
        begin
            want_name_reg <= in_item.base_name;
            want_ext_reg  <= in_item.extension;
            buf_reg       <= in_item.buffer_size;
            scan_idx_reg  <= '0;
        end
        if (state_reg == S_LAY1)
            start_reg <= 20'(rsv_reg) + 20'(fats_reg * spf_reg) + 20'(root_secs);
        if (state_reg == S_LAY2)
        begin
            doff_reg  <= 32'(start_reg * bps_reg);
            csize_reg <= 21'(spc_reg * bps_reg);
        end
        if (state_reg == S_SCAN_CHK)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            c_reg        <= dir_rdata_reg.cluster;
            written_reg  <= '0;
            n_reg        <= '0;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg    <= 32'(c_reg[11:0] - 12'd2) * 32'(csize_reg);
            copy_reg    <= copy_next;
            written_reg <= written_reg + 32'(copy_next);
        end
        if (state_reg == S_RDHI)
            lo_reg <= tbl_rdata_reg;
        if (state_reg == S_NEXT)
        begin
            pend_reg.source_offset <= doff_reg + prod_reg;
            pend_reg.copy_length   <= copy_reg[19:0];
            pend_reg.status        <= ST_MORE;
            pend_reg.total_written <= written_reg;
            pend_reg.last_item     <= 1'b0;
            n_reg                  <= n_reg + 1'b1;
            c_reg                  <= c_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_chain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK || state_reg == S_MUL) |-> n_reg <= N_W'(MAX_CHAIN))
        else $error("chain count beyond limit");

    a_written_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK || state_reg == S_NEXT) |-> written_reg <= buf_reg)
        else $error("written bytes exceed buffer");

    a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_MORE) |-> out_reg.last_item)
        else $error("final status without last flag");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !go_on && state_reg == S_CHECK) |=> in_ready)
        else $error("sequencer did not return to idle");
endmodule
